// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; defining ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// File: sv/oqr_pkg.sv
// ----------------------------------------------------------------------------
// Ordered queue package
// Command and status codes and the fixed field widths of the queue.
// ----------------------------------------------------------------------------
package oqr_pkg;

  localparam int unsigned KEY_W    = 16;
  localparam int unsigned FILL_W   = 10;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

endpackage

// File: sv/ordered_queue_remove_by_key.sv
// ----------------------------------------------------------------------------
// Ordered queue with remove by key
// Keeps keys in arrival order; appends at the tail or removes the oldest match.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction on the s_axis channel carries one command in tuser
// (append or remove) and a 16-bit key in tdata. Each command yields exactly
// one result transaction on m_axis with status, fill count after the step and
// the position of a removed entry.
// An append, or a remove refused because the queue is empty, moves its result
// from the done state to the output register; a new command can then be taken.
// A remove scans the stored keys through the RAM read port, one key per cycle,
// then moves every later key one place toward the head, one key per cycle
// over the same port. A remove that finds no match ends once the newest key
// has been checked, with no shift.
// The block takes one command at a time; s_axis_tready is high only between
// commands, and a result waiting in the output register does not stop the
// next command from being accepted. If the receiver stalls while a second
// result is ready, the sequencer holds that result until the register frees.
// After reset the queue is empty; the RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module ordered_queue_remove_by_key #(
  parameter int unsigned DEPTH = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // key[15:0]
  input  logic        s_axis_tuser,  // cmd[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // status[1:0], fill_count[11:2],
                                     // removed_position[20:12], zero[23:21]
);

  import oqr_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [OW-1:0]      occ_q, occ_d;
  logic [OW-1:0]      rd_idx_q, rd_idx_d;
  logic [AW-1:0]      chk_idx_q, chk_idx_d;
  logic               chk_vld_q, chk_vld_d;
  logic [AW-1:0]      hit_q, hit_d;
  logic [KEY_W-1:0]   key_q, key_d;
  status_e            res_status_q, res_status_d;
  logic [FILL_W-1:0]  res_fill_q, res_fill_d;
  logic [POS_W-1:0]   res_pos_q, res_pos_d;
  logic               out_vld_q, out_vld_d;
  logic [23:0]        out_data_q, out_data_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [KEY_W-1:0]   ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [KEY_W-1:0]   ram_rdata;
  logic               rd_issue;
  logic [AW-1:0]      last_idx;
  logic               in_fire;

  oqr_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign rd_issue      = (rd_idx_q < occ_q);
  assign last_idx      = AW'(occ_q - OW'(1));
  assign ram_raddr     = rd_idx_q[AW-1:0];

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    rd_idx_d     = rd_idx_q;
    chk_idx_d    = chk_idx_q;
    chk_vld_d    = chk_vld_q;
    hit_d        = hit_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_fill_d   = res_fill_q;
    res_pos_d    = res_pos_q;
    out_vld_d    = out_vld_q;
    out_data_d   = out_data_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          key_d     = s_axis_tdata;
          res_pos_d = '0;
          if (cmd_e'(s_axis_tuser) == CMD_APPEND) begin
            state_d = S_DONE;
            if (occ_q == OW'(DEPTH)) begin
              res_status_d = ST_FULL;
              res_fill_d   = FILL_W'(occ_q);
            end else begin
              ram_we       = 1'b1;
              ram_waddr    = occ_q[AW-1:0];
              ram_wdata    = s_axis_tdata;
              occ_d        = OW'(occ_q + OW'(1));
              res_status_d = ST_OK;
              res_fill_d   = FILL_W'(occ_q + OW'(1));
            end
          end else if (occ_q == '0) begin
            state_d      = S_DONE;
            res_status_d = ST_EMPTY;
            res_fill_d   = '0;
          end else begin
            state_d   = S_SEARCH;
            rd_idx_d  = '0;
            chk_vld_d = 1'b0;
          end
        end
      end
      S_SEARCH: begin
        if (rd_issue) begin
          rd_idx_d = OW'(rd_idx_q + OW'(1));
        end
        chk_vld_d = rd_issue;
        chk_idx_d = rd_idx_q[AW-1:0];
        if (chk_vld_q) begin
          if (ram_rdata == key_q) begin
            hit_d     = chk_idx_q;
            rd_idx_d  = OW'(chk_idx_q) + OW'(1);
            chk_vld_d = 1'b0;
            state_d   = S_SHIFT;
          end else if (chk_idx_q == last_idx) begin
            res_status_d = ST_NOT_FOUND;
            res_fill_d   = FILL_W'(occ_q);
            res_pos_d    = '0;
            state_d      = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        if (rd_issue) begin
          rd_idx_d = OW'(rd_idx_q + OW'(1));
        end
        chk_vld_d = rd_issue;
        chk_idx_d = rd_idx_q[AW-1:0];
        if (chk_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(chk_idx_q - AW'(1));
          ram_wdata = ram_rdata;
        end
        if (!rd_issue && !chk_vld_q) begin
          occ_d        = OW'(occ_q - OW'(1));
          res_status_d = ST_OK;
          res_fill_d   = FILL_W'(occ_q - OW'(1));
          res_pos_d    = POS_W'(hit_q);
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_data_d = {3'b000, res_pos_q, res_fill_q, res_status_q};
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      occ_q        <= '0;
      rd_idx_q     <= '0;
      chk_idx_q    <= '0;
      chk_vld_q    <= 1'b0;
      hit_q        <= '0;
      key_q        <= '0;
      res_status_q <= ST_OK;
      res_fill_q   <= '0;
      res_pos_q    <= '0;
      out_vld_q    <= 1'b0;
      out_data_q   <= '0;
    end else begin
      state_q      <= state_d;
      occ_q        <= occ_d;
      rd_idx_q     <= rd_idx_d;
      chk_idx_q    <= chk_idx_d;
      chk_vld_q    <= chk_vld_d;
      hit_q        <= hit_d;
      key_q        <= key_d;
      res_status_q <= res_status_d;
      res_fill_q   <= res_fill_d;
      res_pos_q    <= res_pos_d;
      out_vld_q    <= out_vld_d;
      out_data_q   <= out_data_d;
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEVER(a_occ_bound, clk_i, rst_ni, occ_q > OW'(DEPTH),
                "occupancy above depth")
  `ASSERT_PROP(a_append_grows, clk_i, rst_ni,
               in_fire && !s_axis_tuser && occ_q != OW'(DEPTH)
               |=> occ_q == OW'($past(occ_q) + OW'(1)),
               "append did not grow the queue")
  `ASSERT_PROP(a_shift_in_range, clk_i, rst_ni,
               state_q == S_SHIFT && ram_we |-> OW'(ram_waddr) < occ_q - OW'(1),
               "shift writes outside the kept entries")

endmodule

// File: sv/oqr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module oqr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
